@@ rtl/core/fadd_pkg.sv @@
// ----------------------------------------------------------------------------
// fadd_pkg - shared types and constants for the fraction adder
// Field widths, error codes, sequencer states and the divider request and
// response structures.
// ----------------------------------------------------------------------------
package fadd_pkg;

  // Input field widths
  localparam int unsigned IN_FIELD_W = 16;
  localparam int unsigned IN_DATA_W  = 64;

  // Output field widths
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = 30;
  localparam int unsigned OUT_DATA_W = 128;

  // Product and divider widths
  localparam int unsigned PROD_W = 32;
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned CNT_W  = 6;

  // Error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_NEG_DEN  = 2'd2
  } err_code_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_MUL_D,
    S_GCD,
    S_GCD_W,
    S_QN,
    S_QN_W,
    S_QD,
    S_QD_W,
    S_WH,
    S_WH_W,
    S_FIN
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  // Classify one denominator.
  function automatic err_code_t den_check(input logic [IN_FIELD_W-1:0] d);
    err_code_t e;
    if (d == '0) begin
      e = ERR_ZERO_DEN;
    end else if (d[IN_FIELD_W-1]) begin
      e = ERR_NEG_DEN;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

endpackage

@@ rtl/core/fadd_mul.sv @@
// ----------------------------------------------------------------------------
// fadd_mul - registered 16 x 16 signed multiplier
// One product per cycle, available in the cycle after the operands.
// ----------------------------------------------------------------------------
module fadd_mul (
  input  logic                                clk,
  input  logic signed [fadd_pkg::IN_FIELD_W-1:0] op_a,
  input  logic signed [fadd_pkg::IN_FIELD_W-1:0] op_b,
  output logic signed [fadd_pkg::PROD_W-1:0]     prod
);
  import fadd_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // Product register; the full 32-bit signed product of two 16-bit values.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/fadd_div.sv @@
// ----------------------------------------------------------------------------
// fadd_div - iterative unsigned restoring divider
// Gives quotient and remainder of two 32-bit values, one quotient bit per
// cycle; done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
module fadd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fadd_pkg::div_req_t req,
  output fadd_pkg::div_rsp_t rsp
);
  import fadd_pkg::*;

  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             neg;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    neg     = diff[DIV_W+1];
  end

  // Control: step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ~neg};
      rem_r <= neg ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/core/fraction_add_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_add_reduce - adds two signed fractions and reduces the sum
// Checks the denominators, forms the cross-multiplied sum, reduces it by its
// Euclidean gcd and splits it into a whole part and an absolute remainder.
//
//   Channel   Direction  Payload
//   in_*      slave      num_a, den_a, num_b, den_b (64 bits)
//   out_*     master     error_code, sum_num, sum_den, whole_part,
//                        frac_remainder (128 bits)
//
// An item with a bad denominator goes straight to the final state, a zero
// sum skips the divisions, and otherwise the item runs one division per
// Euclid step and then three more (numerator, denominator, whole part);
// every division runs through one shared restoring divider.
// Reset clears the sequencer and the output valid. in_tready is high only
// while idle; a finished result waits in the output register, and the next
// transaction is taken while it waits. A second finished item holds in the
// final state until the output register is free, and the input stalls.
// ----------------------------------------------------------------------------
module fraction_add_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  // num_a [15:0], den_a [31:16], num_b [47:32], den_b [63:48]
  input  logic [fadd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // error_code [1:0], sum_num [33:2], sum_den [63:34], whole_part [95:64],
  // frac_remainder [125:96], zero [127:126]
  output logic [fadd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import fadd_pkg::*;

  state_t state_r, state_nxt;

  // Captured operands
  logic signed [IN_FIELD_W-1:0] na_r, da_r, nb_r, db_r;

  // Working and result registers
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic [DIV_W-1:0]        mag_r;
  logic                    neg_r;
  logic [DIV_W-1:0]        ga_r, gb_r;
  logic signed [NUM_W-1:0] whole_r;
  logic [DEN_W-1:0]        frem_r;
  err_code_t               err_r;

  // Output register
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_valid_r;

  // Shared units
  logic signed [IN_FIELD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod;
  div_req_t                     div_req;
  div_rsp_t                     div_rsp;

  logic      in_acc;
  logic      out_free;
  err_code_t err_a, err_b, err_in;
  logic [NUM_W-1:0] num_abs;

  fadd_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  fadd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshake and input checks
  always_comb begin
    in_tready = (state_r == S_IDLE);
    in_acc    = in_tvalid && in_tready;
    out_free  = !out_valid_r || out_tready;
    err_a     = den_check(in_tdata[31:16]);
    err_b     = den_check(in_tdata[63:48]);
    err_in    = (err_a != ERR_NONE) ? err_a : err_b;
    num_abs   = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  end

  // Sequencer next state and shared unit operand selection
  always_comb begin
    state_nxt        = state_r;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = ga_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (err_in != ERR_NONE) ? S_FIN : S_MUL_A;
        end
      end
      S_MUL_A: begin
        mul_a     = na_r;
        mul_b     = db_r;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        mul_a     = nb_r;
        mul_b     = da_r;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        mul_a     = da_r;
        mul_b     = db_r;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        state_nxt = (num_r == '0) ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (gb_r == '0) begin
          state_nxt = S_QN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ga_r;
          div_req.divisor  = gb_r;
          state_nxt        = S_GCD_W;
        end
      end
      S_GCD_W: begin
        if (div_rsp.done) begin
          state_nxt = S_GCD;
        end
      end
      S_QN: begin
        div_req.start = 1'b1;
        state_nxt     = S_QN_W;
      end
      S_QN_W: begin
        if (div_rsp.done) begin
          state_nxt = S_QD;
        end
      end
      S_QD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(den_r);
        state_nxt        = S_QD_W;
      end
      S_QD_W: begin
        if (div_rsp.done) begin
          state_nxt = S_WH;
        end
      end
      S_WH: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIV_W'(den_r);
        state_nxt       = S_WH_W;
      end
      S_WH_W: begin
        if (div_rsp.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers, updated per sequencer step
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          na_r    <= in_tdata[15:0];
          da_r    <= in_tdata[31:16];
          nb_r    <= in_tdata[47:32];
          db_r    <= in_tdata[63:48];
          err_r   <= err_in;
          num_r   <= '0;
          den_r   <= '0;
          whole_r <= '0;
          frem_r  <= '0;
        end
      end
      S_MUL_B: begin
        num_r <= prod;
      end
      S_MUL_C: begin
        num_r <= num_r + prod;
      end
      S_MUL_D: begin
        if (num_r == '0) begin
          den_r <= DEN_W'(1);
        end else begin
          den_r <= prod[DEN_W-1:0];
          mag_r <= num_abs;
          neg_r <= num_r[NUM_W-1];
          ga_r  <= num_abs;
          gb_r  <= DIV_W'(prod[DEN_W-1:0]);
        end
      end
      S_GCD_W: begin
        if (div_rsp.done) begin
          ga_r <= gb_r;
          gb_r <= div_rsp.rem;
        end
      end
      S_QN_W: begin
        if (div_rsp.done) begin
          mag_r <= div_rsp.quo;
        end
      end
      S_QD_W: begin
        if (div_rsp.done) begin
          den_r <= div_rsp.quo[DEN_W-1:0];
        end
      end
      S_WH_W: begin
        if (div_rsp.done) begin
          num_r   <= neg_r ? NUM_W'(-mag_r) : NUM_W'(mag_r);
          whole_r <= neg_r ? NUM_W'(-div_rsp.quo) : NUM_W'(div_rsp.quo);
          frem_r  <= div_rsp.rem[DEN_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded from the finished item once it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= {2'b00, frem_r, whole_r, den_r, num_r, err_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
